/* hdl/q2e_pkg.sv */
// Shared types and constants for the quaternion to Euler angle core.
// Holds datapath widths, the CORDIC vector record and the arctangent table.
// No dependencies.
`default_nettype none
package q2e_pkg;

    // CORDIC x/y width: Q28 operands reach about 2^33, plus gain and pre-rotation
    localparam int CW = 37;
    // angle accumulator, 1/65536 hundredth degree
    localparam int AW = 32;
    // saturated asin argument, +-2^28
    localparam int SW = 30;
    // square root radicand and remainder
    localparam int RW = 58;
    // square root result bits, covers 2^28
    localparam int QW = 29;
    localparam int TABLE_LEN = 24;

    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(589824000);
    localparam logic signed [CW-1:0] Q28_ONE = CW'(64'sd268435456);
    localparam logic signed [SW-1:0] S_MAX = SW'(268435456);
    localparam logic signed [SW-1:0] S_MIN = -SW'(268435456);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 zero;
    } cordic_vec_t;

    // atan(2^-i) in 1/65536 hundredth degree, rounded to nearest
    function automatic logic signed [AW-1:0] atan_entry(input int idx);
        logic signed [AW-1:0] v;
        unique case (idx)
            0:  v = AW'(294912000);
            1:  v = AW'(174096719);
            2:  v = AW'(91987925);
            3:  v = AW'(46694507);
            4:  v = AW'(23437865);
            5:  v = AW'(11730358);
            6:  v = AW'(5866610);
            7:  v = AW'(2933484);
            8:  v = AW'(1466764);
            9:  v = AW'(733385);
            10: v = AW'(366693);
            11: v = AW'(183346);
            12: v = AW'(91673);
            13: v = AW'(45837);
            14: v = AW'(22918);
            15: v = AW'(11459);
            16: v = AW'(5730);
            17: v = AW'(2865);
            18: v = AW'(1432);
            19: v = AW'(716);
            20: v = AW'(358);
            21: v = AW'(179);
            22: v = AW'(90);
            23: v = AW'(45);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hdl/q2e_sqrt_cell.sv */
// One cell of the pipelined bit-by-bit integer square root.
// Resolves one result bit and passes a side payload along. Uses q2e_pkg.
`default_nettype none
module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int K  = 0,
    parameter int DW = 1
) (
    input  wire logic          clk,
    input  wire logic [RW-1:0] in_rem,
    input  wire logic [RW-1:0] in_res,
    input  wire logic [DW-1:0] in_data,
    output logic      [RW-1:0] out_rem,
    output logic      [RW-1:0] out_res,
    output logic      [DW-1:0] out_data
);

    localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] res_reg;
    logic [RW-1:0] res_next;
    logic [DW-1:0] data_reg;
    logic [RW-1:0] trial;

    always_comb
    begin
        trial = in_res + BIT;
        if (in_rem >= trial)
        begin
            rem_next = in_rem - trial;
            res_next = (in_res >> 1) + BIT;
        end
        else
        begin
            rem_next = in_rem;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        data_reg <= in_data;
    end

    assign out_rem  = rem_reg;
    assign out_res  = res_reg;
    assign out_data = data_reg;

endmodule
`default_nettype wire

/* hdl/q2e_cordic_cell.sv */
// One vectoring micro-rotation of the CORDIC chain.
// Rotates toward the X axis by atan(2^-I). Uses q2e_pkg.
`default_nettype none
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int I = 0
) (
    input  wire logic        clk,
    input  wire cordic_vec_t in_vec,
    output cordic_vec_t      out_vec
);

    localparam logic signed [AW-1:0] ANGLE = atan_entry(I);

    cordic_vec_t vec_reg;
    cordic_vec_t vec_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb
    begin
        xs = in_vec.x >>> I;
        ys = in_vec.y >>> I;
        vec_next.zero = in_vec.zero;
        if (!in_vec.y[CW-1])
        begin
            vec_next.x   = in_vec.x + ys;
            vec_next.y   = in_vec.y - xs;
            vec_next.acc = in_vec.acc + ANGLE;
        end
        else
        begin
            vec_next.x   = in_vec.x - ys;
            vec_next.y   = in_vec.y + xs;
            vec_next.acc = in_vec.acc - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign out_vec = vec_reg;

endmodule
`default_nettype wire

/* hdl/q2e_atan2.sv */
// Pipelined atan2 in hundredths of a degree: quarter-turn pre-rotation,
// a chain of q2e_cordic_cell, then rounding and clamp. Uses q2e_pkg.
`default_nettype none
module q2e_atan2
    import q2e_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                 clk,
    input  wire logic signed [CW-1:0] y,
    input  wire logic signed [CW-1:0] x,
    output logic signed [15:0]        angle
);

    cordic_vec_t          pre_reg;
    cordic_vec_t          pre_next;
    cordic_vec_t          chain [0:STEPS];
    logic signed [15:0]   angle_reg;
    logic signed [15:0]   angle_next;
    logic signed [AW:0]   rounded;
    logic signed [AW-16:0] whole;

    always_comb
    begin
        pre_next.zero = (x == '0) && (y == '0);
        if (x[CW-1])
        begin
            if (!y[CW-1])
            begin
                pre_next.x   = y;
                pre_next.y   = -x;
                pre_next.acc = QUARTER_TURN;
            end
            else
            begin
                pre_next.x   = -y;
                pre_next.y   = x;
                pre_next.acc = -QUARTER_TURN;
            end
        end
        else
        begin
            pre_next.x   = x;
            pre_next.y   = y;
            pre_next.acc = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg <= pre_next;
    end

    assign chain[0] = pre_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        q2e_cordic_cell #(
            .I (i)
        ) u_cell (
            .clk     (clk),
            .in_vec  (chain[i]),
            .out_vec (chain[i+1])
        );
    end

    // round half up to whole hundredths, clamp to half a turn
    always_comb
    begin
        rounded = {chain[STEPS].acc[AW-1], chain[STEPS].acc} + (AW+1)'(32768);
        whole   = rounded[AW:16];
        if (chain[STEPS].zero)
            angle_next = '0;
        else if (whole > (AW-15)'(18000))
            angle_next = 16'sd18000;
        else if (whole < -(AW-15)'(18000))
            angle_next = -16'sd18000;
        else
            angle_next = whole[15:0];
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire

/* hdl/quaternion_to_euler_angles_core.sv */
// Quaternion to Z-Y-X Euler angles, fully pipelined top level.
// Uses q2e_pkg, q2e_sqrt_cell and q2e_atan2.
//
//  channel   handshake      payload
//  request   start / busy   quat_w, quat_x, quat_y, quat_z
//  result    done           roll_cdeg, pitch_cdeg, heading_cdeg
//
// A request is taken in every cycle that start is high; busy stays low.
// The pipeline runs through product, sum, square and asin radicand
// stages, 29 square root cells, then the CORDIC chain with its
// pre-rotation and rounding stages and one output stage.
// Reset clears only the valid pipeline; done pulses one cycle per request.
`default_nettype none
module quaternion_to_euler_angles_core
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    output logic                    done,
    output logic signed [15:0]      roll_cdeg,
    output logic signed [14:0]      pitch_cdeg,
    output logic        [15:0]      heading_cdeg
);

    localparam int LAT = CORDIC_STEPS + 36;
    localparam int DW  = 4 * CW + SW;
    localparam logic [RW-1:0] ONE_SQ = RW'(1) << 56;

    logic [LAT-1:0] valid_reg;

    // product stage
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [31:0] wz_reg, xy_reg, zz_reg;

    // sum stage
    logic signed [CW-1:0] ry_reg, rx_reg, hy_reg, hx_reg;
    logic signed [CW-1:0] ry_next, rx_next, hy_next, hx_next, s_wide;
    logic signed [SW-1:0] s_reg, s_next;
    logic        [QW-1:0] s_mag;

    // square stage
    logic [RW-1:0]        sq_reg;
    logic [DW-1:0]        pay3_reg;
    // radicand stage
    logic [RW-1:0]        rem4_reg;
    logic [DW-1:0]        pay4_reg;

    logic [RW-1:0]        rem_chain [0:QW];
    logic [RW-1:0]        res_chain [0:QW];
    logic [DW-1:0]        pay_chain [0:QW];

    logic signed [CW-1:0] roll_y, roll_x, head_y, head_x, pitch_y, pitch_x;
    logic signed [SW-1:0] s_out;
    logic signed [15:0]   roll_ang, pitch_ang, head_ang;

    logic signed [14:0]   pitch_next;
    logic        [16:0]   head_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], start};
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= quat_w * quat_x;
        yz_reg <= quat_y * quat_z;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        wy_reg <= quat_w * quat_y;
        zx_reg <= quat_z * quat_x;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        zz_reg <= quat_z * quat_z;
    end

    always_comb
    begin
        ry_next = (CW'(wx_reg) + CW'(yz_reg)) <<< 1;
        rx_next = Q28_ONE - ((CW'(xx_reg) + CW'(yy_reg)) <<< 1);
        hy_next = (CW'(wz_reg) + CW'(xy_reg)) <<< 1;
        hx_next = Q28_ONE - ((CW'(yy_reg) + CW'(zz_reg)) <<< 1);
        s_wide  = (CW'(wy_reg) - CW'(zx_reg)) <<< 1;
        // saturate the asin argument to +-1.0
        if (s_wide > CW'(S_MAX))
            s_next = S_MAX;
        else if (s_wide < CW'(S_MIN))
            s_next = S_MIN;
        else
            s_next = s_wide[SW-1:0];
        // square the magnitude, at most 2^28
        if (s_reg[SW-1])
            s_mag = QW'(-s_reg);
        else
            s_mag = QW'(s_reg);
    end

    always_ff @(posedge clk)
    begin
        ry_reg   <= ry_next;
        rx_reg   <= rx_next;
        hy_reg   <= hy_next;
        hx_reg   <= hx_next;
        s_reg    <= s_next;
        sq_reg   <= RW'(s_mag) * RW'(s_mag);
        pay3_reg <= {ry_reg, rx_reg, hy_reg, hx_reg, s_reg};
        rem4_reg <= ONE_SQ - sq_reg;
        pay4_reg <= pay3_reg;
    end

    assign rem_chain[0] = rem4_reg;
    assign res_chain[0] = '0;
    assign pay_chain[0] = pay4_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(
            .K  (QW - 1 - k),
            .DW (DW)
        ) u_cell (
            .clk      (clk),
            .in_rem   (rem_chain[k]),
            .in_res   (res_chain[k]),
            .in_data  (pay_chain[k]),
            .out_rem  (rem_chain[k+1]),
            .out_res  (res_chain[k+1]),
            .out_data (pay_chain[k+1])
        );
    end

    assign {roll_y, roll_x, head_y, head_x, s_out} = pay_chain[QW];
    assign pitch_y = CW'(s_out);
    assign pitch_x = CW'({1'b0, res_chain[QW][QW-1:0]});

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk (clk), .y (roll_y), .x (roll_x), .angle (roll_ang)
    );

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk (clk), .y (pitch_y), .x (pitch_x), .angle (pitch_ang)
    );

    q2e_atan2 #(.STEPS(CORDIC_STEPS)) u_head (
        .clk (clk), .y (head_y), .x (head_x), .angle (head_ang)
    );

    always_comb
    begin
        if (pitch_ang > 16'sd9000)
            pitch_next = 15'sd9000;
        else if (pitch_ang < -16'sd9000)
            pitch_next = -15'sd9000;
        else
            pitch_next = pitch_ang[14:0];
        // wrap heading into 0..35999
        if (head_ang[15])
            head_wide = 17'({head_ang[15], head_ang}) + 17'd36000;
        else
            head_wide = 17'({head_ang[15], head_ang});
    end

    always_ff @(posedge clk)
    begin
        roll_cdeg    <= roll_ang;
        pitch_cdeg   <= pitch_next;
        heading_cdeg <= head_wide[15:0];
    end

    assign busy = 1'b0;
    assign done = valid_reg[LAT-1];

endmodule
`default_nettype wire

/* tb/quaternion_to_euler_angles_core_tb.sv */
// Self-checking testbench for quaternion_to_euler_angles_core.
// Predicts roll, pitch and heading with its own CORDIC and square root model.
// Depends on the core RTL and q2e_pkg.
`default_nettype none

class angle_scoreboard;
    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic [15:0]        heading;
    } angles_t;

    static const longint ARCTAN[24] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    angles_t pending_angles[$];
    int      mismatches;
    int      steps;

    function new(int n_steps);
        steps = n_steps;
        mismatches = 0;
    endfunction

    // arithmetic right shift, floor
    static function longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    static function longint floor_sqrt(longint n);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'd1 << 29;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function longint vector_angle(longint y, longint x);
        longint acc, nx, ny, r;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; acc = 64'sd589824000;
            end
            else begin
                nx = -y; ny = x; acc = -64'sd589824000;
            end
            x = nx; y = ny;
        end
        for (int i = 0; i < steps && i < 24; i++) begin
            if (y >= 0) begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                acc += ARCTAN[i];
            end
            else begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                acc -= ARCTAN[i];
            end
            x = nx; y = ny;
        end
        r = shr_floor(acc + 32768, 16);
        if (r > 18000) r = 18000;
        if (r < -18000) r = -18000;
        return r;
    endfunction

    function void note_request(logic signed [15:0] qw, logic signed [15:0] qx,
                               logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, s, c, one, r, p, h;
        angles_t a;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 << 28;
        r = vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y));
        s = 2 * (w * y - z * x);
        if (s > one) s = one;
        if (s < -one) s = -one;
        c = floor_sqrt((64'sd1 << 56) - s * s);
        p = vector_angle(s, c);
        if (p > 9000) p = 9000;
        if (p < -9000) p = -9000;
        h = vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
        if (h < 0) h += 36000;
        a.roll = r[15:0];
        a.pitch = p[14:0];
        a.heading = h[15:0];
        pending_angles.push_back(a);
    endfunction

    function void check_result(logic signed [15:0] roll, logic signed [14:0] pitch,
                               logic [15:0] heading);
        angles_t e;
        if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result roll=%0d pitch=%0d heading=%0d",
                         roll, pitch, heading);
            return;
        end
        e = pending_angles.pop_front();
        if (e.roll !== roll || e.pitch !== pitch || e.heading !== heading) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                         e.roll, e.pitch, e.heading, roll, pitch, heading);
        end
    endfunction
endclass

module quaternion_to_euler_angles_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 36;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] quat_w = '0;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic               done;
    logic signed [15:0] roll_cdeg;
    logic signed [14:0] pitch_cdeg;
    logic [15:0]        heading_cdeg;

    angle_scoreboard angles = new(STEPS);
    int idle_cycles = 0;

    quaternion_to_euler_angles_core #(.CORDIC_STEPS(STEPS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .done(done), .roll_cdeg(roll_cdeg), .pitch_cdeg(pitch_cdeg),
        .heading_cdeg(heading_cdeg)
    );

    always #6 clk = ~clk;

    // sample at the edge; note requests and results, count quiet cycles
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy)
                angles.note_request(quat_w, quat_x, quat_y, quat_z);
            if (done)
                angles.check_result(roll_cdeg, pitch_cdeg, heading_cdeg);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quaternion_to_euler_angles_core_tb: done, errors");
            $finish;
        end
    end

    // hold the request until taken; start stays high into the next request
    task automatic send_request(logic signed [15:0] w, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [15:0] z);
        start <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_sender(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic signed [15:0] any_component();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 65535));
            3: return 16'sd16384;
            4: return -16'sd16384;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    // random unit quaternion in Q14, normalized in real arithmetic
    task automatic send_unit_quaternion();
        real a, b, c, d, n;
        a = $itor($signed($urandom_range(0, 2000))) - 1000.0;
        b = $itor($signed($urandom_range(0, 2000))) - 1000.0;
        c = $itor($signed($urandom_range(0, 2000))) - 1000.0;
        d = $itor($signed($urandom_range(0, 2000))) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) begin
            a = 1.0; n = 1.0;
        end
        send_request(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                     16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    initial begin
        int burst;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, axes, gimbal lock, zero vector, extremes
        send_request(16'sd16384, 0, 0, 0);
        send_request(-16'sd16384, 0, 0, 0);
        send_request(0, 16'sd16384, 0, 0);
        send_request(0, 0, 16'sd16384, 0);
        send_request(0, 0, 0, 16'sd16384);
        send_request(0, 0, 0, -16'sd16384);
        send_request(16'sd11585, 0, 16'sd11585, 0);
        send_request(16'sd11585, 0, -16'sd11585, 0);
        send_request(16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585);
        send_request(0, 0, 0, 0);
        send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_request(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_request(16'sd11585, 0, 0, -16'sd11585);
        send_request(0, 16'sd11585, 16'sd11585, 0);
        send_request(16'sh7fff, 0, 16'sh7fff, 0);
        send_request(-1, -1, -1, -1);
        send_request(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        send_request(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);

        // drain completely once before the random part
        start <= 1'b0;
        while (angles.pending_angles.size() != 0)
            @(posedge clk);

        for (int n = 0; n < 730; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 3) != 0)
                    send_unit_quaternion();
                else
                    send_request(any_component(), any_component(),
                                 any_component(), any_component());
            end
            n += burst;
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 8));
        end

        start <= 1'b0;
        while (angles.pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (angles.mismatches == 0)
            $display("quaternion_to_euler_angles_core_tb: done, clean");
        else
            $display("quaternion_to_euler_angles_core_tb: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
